### sv/vmyp_pkg.sv
// shared constants and types for the yaw/pitch view matrix block
`timescale 1ns / 1ps
`default_nettype none

package vmyp_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int POS_W        = 32;
    localparam int ENT_W        = 32;
    localparam int ANG_IN_W     = 16;
    // q30 magnitude up to and including one
    localparam int Q_W          = 31;
    localparam int X2_W         = 32;
    localparam int TAYLOR_STEPS = 9;
    // angle product, x squared, three stages per series term, final product, quadrant
    localparam int TRIG_LAT     = 2 + 3 * TAYLOR_STEPS + 2;
    localparam int AX_W         = FRAC_BITS + 2;
    localparam int PROD_W       = POS_W + AX_W;
    localparam int SUM_W        = PROD_W + 2;

    localparam logic [40:0]    HALF_PI_Q40 = 41'h1921FB54443;
    localparam logic [Q_W-1:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [63:0]    RND30       = 64'd1 << 29;

    typedef struct packed {
        logic signed [ENT_W-1:0] sn;
        logic signed [ENT_W-1:0] cs;
    } trig_t;

    typedef struct packed {
        logic signed [AX_W-1:0] ax0;
        logic signed [AX_W-1:0] ax2;
        logic signed [AX_W-1:0] ay0;
        logic signed [AX_W-1:0] ay1;
        logic signed [AX_W-1:0] ay2;
        logic signed [AX_W-1:0] az0;
        logic signed [AX_W-1:0] az1;
        logic signed [AX_W-1:0] az2;
    } axes_t;

endpackage

`default_nettype wire

### sv/vmyp_trig.sv
// pipelined q30 sine and cosine of a binary angle, taylor series in horner form
`timescale 1ns / 1ps
`default_nettype none

module vmyp_trig (
    input  wire logic                            aclk,
    input  wire logic                            en,
    input  wire logic [vmyp_pkg::ANGLE_BITS-1:0] angle,
    output vmyp_pkg::trig_t                      res
);
    import vmyp_pkg::*;

    localparam int R_W  = ANGLE_BITS - 2;
    localparam int XS_W = R_W + 42;
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;

    logic [XS_W-1:0]  xp_w;
    logic [63:0]      x2p_w;
    logic [Q_W-1:0]   x_reg;
    logic [1:0]       q1_reg;
    logic [X2_W-1:0]  x2_reg;
    logic [Q_W-1:0]   x1_reg;
    logic [1:0]       q2_reg;

    logic [X2_W-1:0]  st_x2 [TAYLOR_STEPS];
    logic [Q_W-1:0]   st_x  [TAYLOR_STEPS];
    logic [Q_W-1:0]   st_ts [TAYLOR_STEPS];
    logic [Q_W-1:0]   st_tc [TAYLOR_STEPS];
    logic [1:0]       st_q  [TAYLOR_STEPS];

    logic [31:0]      a_ps_reg [TAYLOR_STEPS];
    logic [31:0]      a_pc_reg [TAYLOR_STEPS];
    logic [X2_W-1:0]  a_x2_reg [TAYLOR_STEPS];
    logic [Q_W-1:0]   a_x_reg  [TAYLOR_STEPS];
    logic [1:0]       a_q_reg  [TAYLOR_STEPS];
    logic [31:0]      b_ps_reg [TAYLOR_STEPS];
    logic [31:0]      b_pc_reg [TAYLOR_STEPS];
    logic [31:0]      b_qs_reg [TAYLOR_STEPS];
    logic [31:0]      b_qc_reg [TAYLOR_STEPS];
    logic [X2_W-1:0]  b_x2_reg [TAYLOR_STEPS];
    logic [Q_W-1:0]   b_x_reg  [TAYLOR_STEPS];
    logic [1:0]       b_q_reg  [TAYLOR_STEPS];
    logic [Q_W-1:0]   c_ts_reg [TAYLOR_STEPS];
    logic [Q_W-1:0]   c_tc_reg [TAYLOR_STEPS];
    logic [X2_W-1:0]  c_x2_reg [TAYLOR_STEPS];
    logic [Q_W-1:0]   c_x_reg  [TAYLOR_STEPS];
    logic [1:0]       c_q_reg  [TAYLOR_STEPS];

    logic [63:0]      fs_w;
    logic [Q_W-1:0]   f_s_reg;
    logic [Q_W-1:0]   f_c_reg;
    logic [1:0]       f_q_reg;
    logic signed [ENT_W-1:0] s_w;
    logic signed [ENT_W-1:0] c_w;
    trig_t            res_next;
    trig_t            res_reg;

    // quadrant remainder scaled to radians in q30
    always_comb begin
        xp_w  = XS_W'(angle[R_W-1:0]) * XS_W'(HALF_PI_Q40)
              + (XS_W'(1) << (ANGLE_BITS + 7));
        x2p_w = 64'(x_reg) * 64'(x_reg) + RND30;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg  <= xp_w[ANGLE_BITS + 8 +: Q_W];
            q1_reg <= angle[ANGLE_BITS-1 -: 2];
            x2_reg <= x2p_w[30 +: X2_W];
            x1_reg <= x_reg;
            q2_reg <= q1_reg;
        end
    end

    for (genvar j = 0; j < TAYLOR_STEPS; j++) begin : g_step
        localparam int K  = TAYLOR_STEPS - j;
        localparam int DS = (2 * K) * (2 * K + 1);
        localparam int DC = (2 * K - 1) * (2 * K);
        localparam logic [31:0] MS = 32'((64'd1 << 32) / DS);
        localparam logic [31:0] MC = 32'((64'd1 << 32) / DC);

        logic [63:0] ps_w;
        logic [63:0] pc_w;
        logic [63:0] qs_w;
        logic [63:0] qc_w;
        logic [31:0] rs_w;
        logic [31:0] rc_w;
        logic [31:0] qsa_w;
        logic [31:0] qca_w;

        if (j == 0) begin : g_first
            assign st_x2[j] = x2_reg;
            assign st_x[j]  = x1_reg;
            assign st_ts[j] = Q30_ONE;
            assign st_tc[j] = Q30_ONE;
            assign st_q[j]  = q2_reg;
        end else begin : g_next
            assign st_x2[j] = c_x2_reg[j-1];
            assign st_x[j]  = c_x_reg[j-1];
            assign st_ts[j] = c_ts_reg[j-1];
            assign st_tc[j] = c_tc_reg[j-1];
            assign st_q[j]  = c_q_reg[j-1];
        end

        always_comb begin
            ps_w  = 64'(st_x2[j]) * 64'(st_ts[j]) + RND30;
            pc_w  = 64'(st_x2[j]) * 64'(st_tc[j]) + RND30;
            // reciprocal estimate is exact or one short
            qs_w  = 64'(a_ps_reg[j]) * 64'(MS);
            qc_w  = 64'(a_pc_reg[j]) * 64'(MC);
            rs_w  = b_ps_reg[j] - 32'(b_qs_reg[j] * 32'(DS));
            rc_w  = b_pc_reg[j] - 32'(b_qc_reg[j] * 32'(DC));
            qsa_w = b_qs_reg[j] + ((rs_w >= 32'(DS)) ? 32'd1 : 32'd0);
            qca_w = b_qc_reg[j] + ((rc_w >= 32'(DC)) ? 32'd1 : 32'd0);
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                a_ps_reg[j] <= ps_w[30 +: 32];
                a_pc_reg[j] <= pc_w[30 +: 32];
                a_x2_reg[j] <= st_x2[j];
                a_x_reg[j]  <= st_x[j];
                a_q_reg[j]  <= st_q[j];
                b_ps_reg[j] <= a_ps_reg[j];
                b_pc_reg[j] <= a_pc_reg[j];
                b_qs_reg[j] <= qs_w[63:32];
                b_qc_reg[j] <= qc_w[63:32];
                b_x2_reg[j] <= a_x2_reg[j];
                b_x_reg[j]  <= a_x_reg[j];
                b_q_reg[j]  <= a_q_reg[j];
                c_ts_reg[j] <= Q30_ONE - Q_W'(qsa_w);
                c_tc_reg[j] <= Q30_ONE - Q_W'(qca_w);
                c_x2_reg[j] <= b_x2_reg[j];
                c_x_reg[j]  <= b_x_reg[j];
                c_q_reg[j]  <= b_q_reg[j];
            end
        end
    end

    always_comb begin
        fs_w = 64'(c_x_reg[TAYLOR_STEPS-1]) * 64'(c_ts_reg[TAYLOR_STEPS-1]) + RND30;
        s_w  = ENT_W'(f_s_reg);
        c_w  = ENT_W'(f_c_reg);
        case (f_q_reg)
            QUAD_0: begin
                res_next.sn = s_w;
                res_next.cs = c_w;
            end
            QUAD_1: begin
                res_next.sn = c_w;
                res_next.cs = -s_w;
            end
            QUAD_2: begin
                res_next.sn = -s_w;
                res_next.cs = -c_w;
            end
            default: begin
                res_next.sn = -c_w;
                res_next.cs = s_w;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_s_reg <= fs_w[30 +: Q_W];
            f_c_reg <= c_tc_reg[TAYLOR_STEPS-1];
            f_q_reg <= c_q_reg[TAYLOR_STEPS-1];
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

### sv/view_matrix_from_yaw_pitch.sv
// view matrix from camera position, yaw and pitch, emitted as four columns
// Input channel s_*: one transaction carries a camera position (signed fixed
// point) and two binary angles. Result channel m_*: four transactions per
// input, columns 0 to 3 in order, last_column high on column 3, degenerate
// high on all four when the sine of pitch is zero (entries then read zero).
// The path is a 37-stage pipeline: one input register, 31 stages for the
// two sine/cosine units (three stages per series term) and five for the
// axis products, rounding and the translation dot products, followed by
// the column output register.
// Throughput is set by the four column transactions on the single result
// channel; s_ready stays high while the pipeline tail is free, so poses
// may arrive back to back and queue in the pipeline.
// Stall: with m_ready low the whole pipeline holds once its tail is full;
// nothing is dropped or repeated. Reset (aresetn low, synchronous) empties
// the pipeline and the output register; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module view_matrix_from_yaw_pitch (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [vmyp_pkg::POS_W-1:0]       s_pos_x,
    input  wire logic signed [vmyp_pkg::POS_W-1:0]       s_pos_y,
    input  wire logic signed [vmyp_pkg::POS_W-1:0]       s_pos_z,
    input  wire logic        [vmyp_pkg::ANG_IN_W-1:0]    s_yaw_angle,
    input  wire logic        [vmyp_pkg::ANG_IN_W-1:0]    s_pitch_angle,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic [1:0]                                   m_col_index,
    output logic signed [vmyp_pkg::ENT_W-1:0]            m_entry_0,
    output logic signed [vmyp_pkg::ENT_W-1:0]            m_entry_1,
    output logic signed [vmyp_pkg::ENT_W-1:0]            m_entry_2,
    output logic signed [vmyp_pkg::ENT_W-1:0]            m_entry_3,
    output logic                                         m_last_column,
    output logic                                         m_degenerate
);
    import vmyp_pkg::*;

    localparam int VLD_N = 1 + TRIG_LAT + 5;
    localparam int POS_N = TRIG_LAT + 3;
    localparam logic [1:0] COL_X = 2'd0;
    localparam logic [1:0] COL_Y = 2'd1;
    localparam logic [1:0] COL_Z = 2'd2;
    localparam logic [1:0] COL_T = 2'd3;

    function automatic logic [Q_W-1:0] mag_of(input logic signed [ENT_W-1:0] v);
        logic [ENT_W-1:0] m;
        m = (v < 0) ? ENT_W'(-v) : ENT_W'(v);
        return m[Q_W-1:0];
    endfunction

    function automatic logic [Q_W-1:0] mul_mag(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b) + RND30;
        return p[30 +: Q_W];
    endfunction

    function automatic logic signed [AX_W-1:0] to_frac(input logic [Q_W-1:0] m,
                                                       input logic neg);
        logic [Q_W:0] r;
        r = ((Q_W + 1)'(m) + ((Q_W + 1)'(1) << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return neg ? -AX_W'(r) : AX_W'(r);
    endfunction

    // minus the dot product, rounded half away from zero and saturated
    function automatic logic signed [ENT_W-1:0] neg_dot(input logic signed [SUM_W-1:0] s);
        logic          neg;
        logic [SUM_W-1:0] m;
        neg = (s > 0);
        m   = (s < 0) ? SUM_W'(-s) : SUM_W'(s);
        m   = (m + (SUM_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (!neg && m > SUM_W'(64'h7FFF_FFFF)) begin
            m = SUM_W'(64'h7FFF_FFFF);
        end
        if (neg && m > SUM_W'(64'h8000_0000)) begin
            m = SUM_W'(64'h8000_0000);
        end
        return neg ? -ENT_W'(m) : ENT_W'(m);
    endfunction

    logic [VLD_N-1:0]        vld_reg;
    logic                    en;
    logic                    load;

    logic signed [POS_W-1:0] px_reg [POS_N];
    logic signed [POS_W-1:0] py_reg [POS_N];
    logic signed [POS_W-1:0] pz_reg [POS_N];
    logic [ANGLE_BITS-1:0]   yaw0_reg;
    logic [ANGLE_BITS-1:0]   pitch0_reg;
    trig_t                   yaw_t;
    trig_t                   pitch_t;

    // stage 1: magnitudes and q30 products
    logic                    p1_deg_reg;
    logic                    p1_sg_reg;
    logic [Q_W-1:0]          p1_sy_reg, p1_cy_reg, p1_sp_reg, p1_cp_reg;
    logic                    p1_sy_n_reg, p1_cy_n_reg, p1_cp_n_reg;
    logic [Q_W-1:0]          p1_cpcy_reg, p1_cpsy_reg, p1_cysp_reg, p1_sysp_reg;
    logic                    p1_cpcy_n_reg, p1_cpsy_n_reg, p1_cysp_n_reg, p1_sysp_n_reg;

    axes_t                   p2_ax_next;
    axes_t                   p2_ax_reg, p3_ax_reg, p4_ax_reg, o_ax_reg;
    logic                    p2_deg_reg, p3_deg_reg, p4_deg_reg, p5_deg_reg, o_deg_reg;
    axes_t                   p5_ax_reg;

    logic signed [PROD_W-1:0] m_x0_reg, m_x2_reg;
    logic signed [PROD_W-1:0] m_y0_reg, m_y1_reg, m_y2_reg;
    logic signed [PROD_W-1:0] m_z0_reg, m_z1_reg, m_z2_reg;
    logic signed [SUM_W-1:0]  s_x_reg, s_y_reg, s_z_reg;
    logic signed [ENT_W-1:0]  t_x_reg, t_y_reg, t_z_reg;
    logic signed [ENT_W-1:0]  o_tx_reg, o_ty_reg, o_tz_reg;

    logic                    mv_reg;
    logic [1:0]              col_reg;

    assign load    = vld_reg[VLD_N-1] && (!mv_reg || (m_ready && col_reg == COL_T));
    assign en      = !vld_reg[VLD_N-1] || load;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[VLD_N-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg[0]  <= s_pos_x;
            py_reg[0]  <= s_pos_y;
            pz_reg[0]  <= s_pos_z;
            yaw0_reg   <= ANGLE_BITS'(s_yaw_angle);
            pitch0_reg <= ANGLE_BITS'(s_pitch_angle);
            for (int i = 1; i < POS_N; i++) begin
                px_reg[i] <= px_reg[i-1];
                py_reg[i] <= py_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    vmyp_trig u_trig_yaw (
        .aclk  (aclk),
        .en    (en),
        .angle (yaw0_reg),
        .res   (yaw_t)
    );

    vmyp_trig u_trig_pitch (
        .aclk  (aclk),
        .en    (en),
        .angle (pitch0_reg),
        .res   (pitch_t)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_deg_reg    <= (pitch_t.sn == '0);
            p1_sg_reg     <= (pitch_t.sn < 0);
            p1_sy_reg     <= mag_of(yaw_t.sn);
            p1_cy_reg     <= mag_of(yaw_t.cs);
            p1_sp_reg     <= mag_of(pitch_t.sn);
            p1_cp_reg     <= mag_of(pitch_t.cs);
            p1_sy_n_reg   <= (yaw_t.sn < 0);
            p1_cy_n_reg   <= (yaw_t.cs < 0);
            p1_cp_n_reg   <= (pitch_t.cs < 0);
            p1_cpcy_reg   <= mul_mag(mag_of(pitch_t.cs), mag_of(yaw_t.cs));
            p1_cpsy_reg   <= mul_mag(mag_of(pitch_t.cs), mag_of(yaw_t.sn));
            p1_cysp_reg   <= mul_mag(mag_of(yaw_t.cs), mag_of(pitch_t.sn));
            p1_sysp_reg   <= mul_mag(mag_of(yaw_t.sn), mag_of(pitch_t.sn));
            p1_cpcy_n_reg <= (pitch_t.cs < 0) != (yaw_t.cs < 0);
            p1_cpsy_n_reg <= (pitch_t.cs < 0) != (yaw_t.sn < 0);
            p1_cysp_n_reg <= (yaw_t.cs < 0) != (pitch_t.sn < 0);
            p1_sysp_n_reg <= (yaw_t.sn < 0) != (pitch_t.sn < 0);
        end
    end

    // sign of sin(pitch) orients the side and up axes
    always_comb begin
        p2_ax_next.ax0 = to_frac(p1_sy_reg, p1_sg_reg != p1_sy_n_reg);
        p2_ax_next.ax2 = to_frac(p1_cy_reg, p1_sg_reg == p1_cy_n_reg);
        p2_ax_next.ay0 = to_frac(p1_cpcy_reg, p1_sg_reg == p1_cpcy_n_reg);
        p2_ax_next.ay1 = to_frac(p1_sp_reg, 1'b0);
        p2_ax_next.ay2 = to_frac(p1_cpsy_reg, p1_sg_reg == p1_cpsy_n_reg);
        p2_ax_next.az0 = to_frac(p1_cysp_reg, p1_cysp_n_reg);
        p2_ax_next.az1 = to_frac(p1_cp_reg, p1_cp_n_reg);
        p2_ax_next.az2 = to_frac(p1_sysp_reg, p1_sysp_n_reg);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p2_ax_reg  <= p2_ax_next;
            p2_deg_reg <= p1_deg_reg;

            m_x0_reg   <= PROD_W'(px_reg[POS_N-1]) * PROD_W'(p2_ax_reg.ax0);
            m_x2_reg   <= PROD_W'(pz_reg[POS_N-1]) * PROD_W'(p2_ax_reg.ax2);
            m_y0_reg   <= PROD_W'(px_reg[POS_N-1]) * PROD_W'(p2_ax_reg.ay0);
            m_y1_reg   <= PROD_W'(py_reg[POS_N-1]) * PROD_W'(p2_ax_reg.ay1);
            m_y2_reg   <= PROD_W'(pz_reg[POS_N-1]) * PROD_W'(p2_ax_reg.ay2);
            m_z0_reg   <= PROD_W'(px_reg[POS_N-1]) * PROD_W'(p2_ax_reg.az0);
            m_z1_reg   <= PROD_W'(py_reg[POS_N-1]) * PROD_W'(p2_ax_reg.az1);
            m_z2_reg   <= PROD_W'(pz_reg[POS_N-1]) * PROD_W'(p2_ax_reg.az2);
            p3_ax_reg  <= p2_ax_reg;
            p3_deg_reg <= p2_deg_reg;

            s_x_reg    <= SUM_W'(m_x0_reg) + SUM_W'(m_x2_reg);
            s_y_reg    <= SUM_W'(m_y0_reg) + SUM_W'(m_y1_reg) + SUM_W'(m_y2_reg);
            s_z_reg    <= SUM_W'(m_z0_reg) + SUM_W'(m_z1_reg) + SUM_W'(m_z2_reg);
            p4_ax_reg  <= p3_ax_reg;
            p4_deg_reg <= p3_deg_reg;

            t_x_reg    <= neg_dot(s_x_reg);
            t_y_reg    <= neg_dot(s_y_reg);
            t_z_reg    <= neg_dot(s_z_reg);
            p5_ax_reg  <= p4_ax_reg;
            p5_deg_reg <= p4_deg_reg;
        end
    end

    // column output register, one transaction per column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg  <= 1'b0;
            col_reg <= COL_X;
        end else if (load) begin
            mv_reg  <= 1'b1;
            col_reg <= COL_X;
        end else if (mv_reg && m_ready) begin
            if (col_reg == COL_T) begin
                mv_reg <= 1'b0;
            end else begin
                col_reg <= col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            o_ax_reg  <= p5_ax_reg;
            o_tx_reg  <= t_x_reg;
            o_ty_reg  <= t_y_reg;
            o_tz_reg  <= t_z_reg;
            o_deg_reg <= p5_deg_reg;
        end
    end

    always_comb begin
        case (col_reg)
            COL_X: begin
                m_entry_0 = ENT_W'(o_ax_reg.ax0);
                m_entry_1 = ENT_W'(o_ax_reg.ay0);
                m_entry_2 = ENT_W'(o_ax_reg.az0);
                m_entry_3 = '0;
            end
            COL_Y: begin
                m_entry_0 = '0;
                m_entry_1 = ENT_W'(o_ax_reg.ay1);
                m_entry_2 = ENT_W'(o_ax_reg.az1);
                m_entry_3 = '0;
            end
            COL_Z: begin
                m_entry_0 = ENT_W'(o_ax_reg.ax2);
                m_entry_1 = ENT_W'(o_ax_reg.ay2);
                m_entry_2 = ENT_W'(o_ax_reg.az2);
                m_entry_3 = '0;
            end
            default: begin
                m_entry_0 = o_tx_reg;
                m_entry_1 = o_ty_reg;
                m_entry_2 = o_tz_reg;
                m_entry_3 = ENT_W'(1) <<< FRAC_BITS;
            end
        endcase
        if (o_deg_reg) begin
            m_entry_0 = '0;
            m_entry_1 = '0;
            m_entry_2 = '0;
            m_entry_3 = '0;
        end
    end

    assign m_valid       = mv_reg;
    assign m_col_index   = col_reg;
    assign m_last_column = (col_reg == COL_T);
    assign m_degenerate  = o_deg_reg;

endmodule

`default_nettype wire
